[hw/rtl/dsq_pkg.sv]
package dsq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned TPOS_W  = 16;
  localparam int unsigned MSTATE_W = 10;
  localparam int unsigned RCNT_W  = 16;
  localparam int unsigned MSTART_W = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned OCC_W   = 5;
  localparam int unsigned ENTRY_W = TPOS_W + MSTATE_W + RCNT_W + MSTART_W;

  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_POP    = 2'd1;

  typedef logic [ENTRY_W-1:0] entry_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_POPPED   = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_CLEARED  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } state_t;

  // per-cell control, broadcast along the chain
  typedef struct packed {
    logic cmp_en;
    logic ins;
    logic pop;
  } ctl_t;

  // sign bit of the counter flipped so an unsigned compare gives queue order
  function automatic entry_t pack_key(
    input logic [TPOS_W-1:0]          tp,
    input logic [MSTATE_W-1:0]        ms,
    input logic signed [RCNT_W-1:0]   rc,
    input logic [MSTART_W-1:0]        st
  );
    logic [RCNT_W-1:0] rc_u;
    rc_u = {~rc[RCNT_W-1], rc[RCNT_W-2:0]};
    return {tp, ms, rc_u, st};
  endfunction

endpackage

[hw/rtl/dsq_ifs.sv]
interface dsq_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [dsq_pkg::FUNC_W-1:0]            func;
  logic [dsq_pkg::TPOS_W-1:0]            text_pos;
  logic [dsq_pkg::MSTATE_W-1:0]          machine_state;
  logic signed [dsq_pkg::RCNT_W-1:0]     repeat_count;
  logic [dsq_pkg::MSTART_W-1:0]          match_start;

  modport source (output valid, func, text_pos, machine_state, repeat_count, match_start,
                  input ready);
  modport sink   (input valid, func, text_pos, machine_state, repeat_count, match_start,
                  output ready);
endinterface

interface dsq_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [dsq_pkg::STATUS_W-1:0]          status;
  logic [dsq_pkg::TPOS_W-1:0]            out_text_pos;
  logic [dsq_pkg::MSTATE_W-1:0]          out_machine_state;
  logic signed [dsq_pkg::RCNT_W-1:0]     out_repeat_count;
  logic [dsq_pkg::MSTART_W-1:0]          out_match_start;
  logic [dsq_pkg::OCC_W-1:0]             occupancy;

  modport source (output valid, status, out_text_pos, out_machine_state, out_repeat_count,
                  out_match_start, occupancy, input ready);
  modport sink   (input valid, status, out_text_pos, out_machine_state, out_repeat_count,
                  out_match_start, occupancy, output ready);
endinterface

[hw/rtl/dsq_cell.sv]
module dsq_cell #(
  parameter int unsigned DEPTH = dsq_pkg::QUEUE_DEPTH,
  parameter int unsigned IDX   = 0
) (
  input  logic                         clk,
  input  dsq_pkg::entry_t              key,
  input  logic [$clog2(DEPTH+1)-1:0]   count,
  input  dsq_pkg::entry_t              prev_entry,
  input  logic                         prev_gt,
  input  dsq_pkg::entry_t              next_entry,
  input  dsq_pkg::ctl_t                ctl,
  output dsq_pkg::entry_t              entry,
  output logic                         gt,
  output logic                         eq
);

  localparam int unsigned CNT_W = $clog2(DEPTH+1);

  dsq_pkg::entry_t entry_r, entry_nxt;
  logic            gt_r, eq_r;
  logic            vld;

  assign vld = count > CNT_W'(IDX);

  // insert: first cell above the key takes it, cells beyond take their left neighbour
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins && gt_r) begin
      entry_nxt = prev_gt ? prev_entry : key;
    end else if (ctl.pop) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (ctl.cmp_en) begin
      gt_r <= !vld || (entry_r > key);
      eq_r <= vld && (entry_r == key);
    end
  end

  assign entry = entry_r;
  assign gt    = gt_r;
  assign eq    = eq_r;

endmodule

[hw/rtl/dedup_sorted_priority_queue_top.sv]
// Sorted priority queue of matcher states, built as a chain of QUEUE_DEPTH cells kept in
// ascending order (text position, automaton state, signed count, match start). Each request
// (insert, pop least, clear) yields exactly one response with a status and the occupancy
// after the request; the entry fields are non-zero only for a successful pop. A request
// passes through accept, a parallel compare of the key in every cell, then the shift
// of the chain together with loading the response register. The next request is accepted
// in the cycle after the response is loaded, so a request is not taken before the last one
// is through; a held response stalls the shift step.
// Exact duplicates are dropped, inserts into a full queue are refused, and func 2 or 3 clears.
module dedup_sorted_priority_queue_top #(
  parameter int unsigned QUEUE_DEPTH = dsq_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  dsq_in_if.sink       in_req,
  dsq_out_if.source    out_rsp
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH+1);

  dsq_pkg::state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]                 count_r, count_nxt;
  logic [dsq_pkg::FUNC_W-1:0]       func_r;
  dsq_pkg::entry_t                  key_r;

  // response register
  logic                             out_valid_r, out_valid_nxt;
  dsq_pkg::status_t                 status_r, status_nxt;
  dsq_pkg::entry_t                  pop_r, pop_nxt;

  dsq_pkg::ctl_t                    ctl;
  dsq_pkg::entry_t                  entry_w [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]           gt_w, eq_w;

  logic                             in_fire, slot_free, dup, full, is_ins, is_pop;
  logic [dsq_pkg::RCNT_W-1:0]       pop_rc;

  assign in_fire   = in_req.valid && in_req.ready;
  assign slot_free = !out_valid_r || out_rsp.ready;
  assign dup       = |eq_w;
  assign full      = count_r == CNT_W'(QUEUE_DEPTH);
  assign is_ins    = func_r == dsq_pkg::FN_INSERT;
  assign is_pop    = func_r == dsq_pkg::FN_POP;

  // ---- cell chain ----
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    dsq_pkg::entry_t prev_e, next_e;
    logic            prev_g;
    if (i == 0) begin : g_head
      assign prev_e = key_r;
      assign prev_g = 1'b0;
    end else begin : g_mid
      assign prev_e = entry_w[i-1];
      assign prev_g = gt_w[i-1];
    end
    if (i == QUEUE_DEPTH-1) begin : g_tail
      assign next_e = entry_w[i];
    end else begin : g_body
      assign next_e = entry_w[i+1];
    end

    dsq_cell #(.DEPTH(QUEUE_DEPTH), .IDX(i)) u_cell (
      .clk        (clk),
      .key        (key_r),
      .count      (count_r),
      .prev_entry (prev_e),
      .prev_gt    (prev_g),
      .next_entry (next_e),
      .ctl        (ctl),
      .entry      (entry_w[i]),
      .gt         (gt_w[i]),
      .eq         (eq_w[i])
    );
  end

  // ---- control ----
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    status_nxt    = status_r;
    pop_nxt       = pop_r;
    ctl           = '0;
    in_req.ready  = 1'b0;

    case (state_r)
      dsq_pkg::S_IDLE: begin
        in_req.ready = 1'b1;
        if (in_req.valid) begin
          state_nxt = dsq_pkg::S_CMP;
        end
      end
      dsq_pkg::S_CMP: begin
        ctl.cmp_en = 1'b1;
        state_nxt  = dsq_pkg::S_APPLY;
      end
      dsq_pkg::S_APPLY: begin
        if (slot_free) begin
          state_nxt     = dsq_pkg::S_IDLE;
          out_valid_nxt = 1'b1;
          pop_nxt       = '0;
          if (is_ins) begin
            if (dup) begin
              status_nxt = dsq_pkg::ST_DUP;
            end else if (full) begin
              status_nxt = dsq_pkg::ST_FULL;
            end else begin
              status_nxt = dsq_pkg::ST_INSERTED;
              ctl.ins    = 1'b1;
              count_nxt  = count_r + CNT_W'(1);
            end
          end else if (is_pop) begin
            if (count_r == '0) begin
              status_nxt = dsq_pkg::ST_EMPTY;
            end else begin
              status_nxt = dsq_pkg::ST_POPPED;
              pop_nxt    = entry_w[0];
              ctl.pop    = 1'b1;
              count_nxt  = count_r - CNT_W'(1);
            end
          end else begin
            // func 2 and the unused code both clear
            status_nxt = dsq_pkg::ST_CLEARED;
            count_nxt  = '0;
          end
        end
      end
      default: begin
        state_nxt = dsq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dsq_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    pop_r    <= pop_nxt;
    if (in_fire) begin
      func_r <= in_req.func;
      key_r  <= dsq_pkg::pack_key(in_req.text_pos, in_req.machine_state,
                                  in_req.repeat_count, in_req.match_start);
    end
  end

  // ---- response unpacking ----
  // counter sign bit flipped back; a zeroed word stays zero
  assign pop_rc = (status_r == dsq_pkg::ST_POPPED)
                ? {~pop_r[dsq_pkg::MSTART_W+dsq_pkg::RCNT_W-1],
                   pop_r[dsq_pkg::MSTART_W+dsq_pkg::RCNT_W-2:dsq_pkg::MSTART_W]}
                : '0;

  assign out_rsp.valid             = out_valid_r;
  assign out_rsp.status            = status_r;
  assign out_rsp.out_text_pos      = pop_r[dsq_pkg::ENTRY_W-1 -: dsq_pkg::TPOS_W];
  assign out_rsp.out_machine_state =
    pop_r[dsq_pkg::ENTRY_W-dsq_pkg::TPOS_W-1 -: dsq_pkg::MSTATE_W];
  assign out_rsp.out_repeat_count  = pop_rc;
  assign out_rsp.out_match_start   = pop_r[dsq_pkg::MSTART_W-1:0];
  assign out_rsp.occupancy         = dsq_pkg::OCC_W'(count_r);

  // ---- assertions ----
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("occupancy beyond queue depth");

  a_accept_to_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == dsq_pkg::S_CMP)
    else $error("accepted request did not enter compare");

  a_rsp_from_apply: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == dsq_pkg::S_APPLY)
    else $error("response loaded outside shift step");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.pop) |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("pop did not decrement occupancy");

  a_no_ins_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins |-> !full && !dup)
    else $error("insert applied to full queue or duplicate");

endmodule
